### design/arpc_pkg.sv
// arpc_pkg: shared types and constants of the arp cache next-hop block
// used by arpc_entry_cell, arp_cache_next_hop_top and tb_top; depends on nothing
`default_nettype none
package arpc_pkg;

   localparam int INDEX_W = 6;  // covers tables of up to 64 entries
   localparam int MAC_W   = 48;
   localparam int IP_W    = 32;
   localparam int LIFE_W  = 7;
   localparam int KEY_W   = 16;

   localparam logic [LIFE_W-1:0] LIFE_FULL = 7'd100;
   localparam logic [15:0] ETH_IPV4 = 16'h0800;
   localparam logic [15:0] ETH_ARP  = 16'h0806;

   localparam logic [2:0] ST_DIRECT    = 3'd0;
   localparam logic [2:0] ST_GATEWAY   = 3'd1;
   localparam logic [2:0] ST_NEED_ARP  = 3'd2;
   localparam logic [2:0] ST_ARP_FRAME = 3'd3;
   localparam logic [2:0] ST_LEARNED   = 3'd4;
   localparam logic [2:0] ST_FOREIGN   = 3'd5;
   localparam logic [2:0] ST_FULL      = 3'd6;
   localparam logic [2:0] ST_UNUSED    = 3'd7;

   localparam logic [1:0] CSR_OWN_IP      = 2'd0;
   localparam logic [1:0] CSR_SUBNET_MASK = 2'd1;
   localparam logic [1:0] CSR_GATEWAY_MAC = 2'd2;

   localparam logic CMD_TX = 1'b0;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_FINISH
   } state_type;

   // search token walking down the row of entries
   typedef struct packed {
      logic               valid;
      logic [KEY_W-1:0]   key;
      logic               hit;
      logic [INDEX_W-1:0] hit_idx;
      logic [MAC_W-1:0]   hit_mac;
      logic               free;
      logic [INDEX_W-1:0] free_idx;
   } token_type;

   // table update broadcast to every entry
   typedef struct packed {
      logic               en;
      logic               load;
      logic [INDEX_W-1:0] idx;
      logic [IP_W-1:0]    ip;
      logic [MAC_W-1:0]   mac;
   } entry_wr_type;

endpackage
`default_nettype wire

### design/arpc_entry_cell.sv
// arpc_entry_cell: one table entry (ip, mac, life) plus one stage of the search row
// depends on arpc_pkg
`default_nettype none
module arpc_entry_cell #(
   parameter int CELL_INDEX = 0
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire arpc_pkg::token_type   tok_in,
   output arpc_pkg::token_type        tok_out,
   input  wire arpc_pkg::entry_wr_type wr
);

   localparam logic [arpc_pkg::INDEX_W-1:0] MY_IDX = arpc_pkg::INDEX_W'(CELL_INDEX);

   logic [arpc_pkg::IP_W-1:0]   ip_ff;
   logic [arpc_pkg::MAC_W-1:0]  mac_ff;
   logic [arpc_pkg::LIFE_W-1:0] life_ff, life_in;
   arpc_pkg::token_type         tok_ff, tok_in_nxt;
   logic                        live;

   assign live = (life_ff != '0);

   always_comb begin
      tok_in_nxt = tok_in;
      if (!tok_in.hit && live && ip_ff[arpc_pkg::KEY_W-1:0] == tok_in.key) begin
         tok_in_nxt.hit     = 1'b1;
         tok_in_nxt.hit_idx = MY_IDX;
         tok_in_nxt.hit_mac = mac_ff;
      end
      // first entry with zero life is the fill slot
      if (!tok_in.free && !live) begin
         tok_in_nxt.free     = 1'b1;
         tok_in_nxt.free_idx = MY_IDX;
      end
   end

   always_comb begin
      life_in = life_ff;
      if (wr.en && wr.idx == MY_IDX) begin
         life_in = arpc_pkg::LIFE_FULL;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         life_ff      <= '0;
         tok_ff.valid <= 1'b0;
      end else begin
         life_ff      <= life_in;
         tok_ff.valid <= tok_in_nxt.valid;
      end
      tok_ff.key      <= tok_in_nxt.key;
      tok_ff.hit      <= tok_in_nxt.hit;
      tok_ff.hit_idx  <= tok_in_nxt.hit_idx;
      tok_ff.hit_mac  <= tok_in_nxt.hit_mac;
      tok_ff.free     <= tok_in_nxt.free;
      tok_ff.free_idx <= tok_in_nxt.free_idx;
      if (wr.en && wr.load && wr.idx == MY_IDX) begin
         ip_ff  <= wr.ip;
         mac_ff <= wr.mac;
      end
   end

   assign tok_out = tok_ff;

endmodule
`default_nettype wire

### design/arp_cache_next_hop_top.sv
// arp_cache_next_hop_top: arp cache with next-hop lookup for one network port
// depends on arpc_pkg and arpc_entry_cell
//
// usage:
//  req channel (req_valid/req_stall) carries one item: cmd 0 is a transmit
//  next-hop lookup of req_ip_addr, cmd 1 a received frame header (ethertype,
//  source ip, source mac). rsp channel (rsp_valid/rsp_stall) returns exactly
//  one result per item: status, dest_mac, entry_index.
//  csr port: csr_write with csr_index 0 own ip, 1 subnet mask, 2 gateway mac;
//  other indexes are dropped. write only while the block is idle.
//  timing: every item walks a search token through the row of TABLE_ENTRIES
//  entry cells, one cell per cycle, then the finish state updates the table and
//  loads the response register once it is free. one item is in work at a time,
//  so req_stall stays high from the request transfer until that load; the
//  search time is set by the cell row length.
//  stall: a held response keeps the block in its finish state; a new request
//  may still be taken while a finished response waits on rsp_stall.
//  reset: all entry lives clear (table empty), csr registers read zero.
`default_nettype none
module arp_cache_next_hop_top #(
   parameter int TABLE_ENTRIES = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_cmd,
   input  wire logic [31:0] req_ip_addr,
   input  wire logic [47:0] req_peer_mac_in,
   input  wire logic [15:0] req_ethertype,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_status,
   output logic [47:0]      rsp_dest_mac,
   output logic [2:0]       rsp_entry_index,
   input  wire logic        csr_write,
   input  wire logic [1:0]  csr_index,
   input  wire logic [47:0] csr_data
);

   arpc_pkg::state_type state_ff, state_in;

   logic [31:0] own_ip_ff, subnet_mask_ff;
   logic [47:0] gateway_mac_ff;

   logic        cmd_ff;
   logic [31:0] ip_ff;
   logic [47:0] mac_ff;
   logic [15:0] etype_ff;

   arpc_pkg::token_type    tok [0:TABLE_ENTRIES];
   arpc_pkg::token_type    found_ff;
   arpc_pkg::entry_wr_type wr;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [2:0]  status_ff, status_in;
   logic [47:0] dest_mac_ff, dest_mac_in;
   logic [2:0]  index_ff, index_in;

   logic accept, load, in_sub;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != arpc_pkg::ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         own_ip_ff      <= '0;
         subnet_mask_ff <= '0;
         gateway_mac_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            arpc_pkg::CSR_OWN_IP:      own_ip_ff      <= csr_data[31:0];
            arpc_pkg::CSR_SUBNET_MASK: subnet_mask_ff <= csr_data[31:0];
            arpc_pkg::CSR_GATEWAY_MAC: gateway_mac_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff   <= req_cmd;
         ip_ff    <= req_ip_addr;
         mac_ff   <= req_peer_mac_in;
         etype_ff <= req_ethertype;
      end
      if (state_ff == arpc_pkg::ST_SEARCH && tok[TABLE_ENTRIES].valid) begin
         found_ff <= tok[TABLE_ENTRIES];
      end
   end

   assign tok[0] = '{valid: accept, key: req_ip_addr[arpc_pkg::KEY_W-1:0], default: '0};

   for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_row
      arpc_entry_cell #(
         .CELL_INDEX(g)
      ) u_entry (
         .clock  (clock),
         .reset  (reset),
         .tok_in (tok[g]),
         .tok_out(tok[g+1]),
         .wr     (wr)
      );
   end

   assign in_sub = ((ip_ff & subnet_mask_ff) == (own_ip_ff & subnet_mask_ff));
   assign load   = (state_ff == arpc_pkg::ST_FINISH) && (!rsp_valid_ff || !rsp_stall);

   // result decode and table update, taken when the response register is free
   always_comb begin
      status_in   = arpc_pkg::ST_FOREIGN;
      dest_mac_in = '0;
      index_in    = '0;
      wr          = '0;
      wr.ip       = ip_ff;
      wr.mac      = mac_ff;
      if (cmd_ff == arpc_pkg::CMD_TX) begin
         if (!in_sub) begin
            status_in   = arpc_pkg::ST_GATEWAY;
            dest_mac_in = gateway_mac_ff;
         end else if (found_ff.hit) begin
            status_in   = arpc_pkg::ST_DIRECT;
            dest_mac_in = found_ff.hit_mac;
            index_in    = 3'(found_ff.hit_idx);
            wr.en       = load;
            wr.idx      = found_ff.hit_idx;
         end else begin
            status_in = arpc_pkg::ST_NEED_ARP;
         end
      end else if (etype_ff == arpc_pkg::ETH_IPV4) begin
         if (!in_sub) begin
            status_in = arpc_pkg::ST_FOREIGN;
         end else if (found_ff.hit) begin
            status_in = arpc_pkg::ST_LEARNED;
            index_in  = 3'(found_ff.hit_idx);
            wr.en     = load;
            wr.idx    = found_ff.hit_idx;
         end else if (found_ff.free) begin
            status_in = arpc_pkg::ST_LEARNED;
            index_in  = 3'(found_ff.free_idx);
            wr.en     = load;
            wr.load   = 1'b1;
            wr.idx    = found_ff.free_idx;
         end else begin
            status_in = arpc_pkg::ST_FULL;
         end
      end else if (etype_ff == arpc_pkg::ETH_ARP) begin
         status_in = arpc_pkg::ST_ARP_FRAME;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         arpc_pkg::ST_IDLE:   if (accept) state_in = arpc_pkg::ST_SEARCH;
         arpc_pkg::ST_SEARCH: if (tok[TABLE_ENTRIES].valid) state_in = arpc_pkg::ST_FINISH;
         arpc_pkg::ST_FINISH: if (load) state_in = arpc_pkg::ST_IDLE;
         default:             state_in = arpc_pkg::ST_IDLE;
      endcase
   end

   assign rsp_valid_in = load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= arpc_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         status_ff   <= status_in;
         dest_mac_ff <= dest_mac_in;
         index_ff    <= index_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_dest_mac    = dest_mac_ff;
   assign rsp_entry_index = index_ff;

`ifndef SYNTHESIS
   a_token_in_search: assert property (@(posedge clock) disable iff (reset)
      tok[TABLE_ENTRIES].valid |-> state_ff == arpc_pkg::ST_SEARCH)
      else $error("search token left the row outside search");
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status != arpc_pkg::ST_UNUSED)
      else $error("unused status code on response");
   a_mac_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != arpc_pkg::ST_DIRECT && rsp_status != arpc_pkg::ST_GATEWAY)
      |-> rsp_dest_mac == '0)
      else $error("dest mac set for a status without next hop");
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      load |=> (state_ff == arpc_pkg::ST_IDLE && rsp_valid))
      else $error("finish did not return to idle with a response");
   a_write_finish: assert property (@(posedge clock) disable iff (reset)
      wr.en |-> (state_ff == arpc_pkg::ST_FINISH && load))
      else $error("table written outside a finish transfer");
`endif

endmodule
`default_nettype wire

### bench/tb_top.sv
// tb_top: self-checking bench for arp_cache_next_hop_top, directed then random traffic
// depends on arpc_pkg (status, ethertype and csr codes) and the design sources
// a behavioral next-hop predictor checks every rsp transfer in order
`default_nettype none
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ENTRIES = 8;
   localparam int SETTLE_CYCLES = ENTRIES + 8;
   localparam longint CYCLE_LIMIT = 200000;
   localparam int RANDOM_PER_PHASE = 175;
   localparam logic CMD_RX = 1'b1;
   localparam logic [1:0] CSR_UNMAPPED = 2'd3;
   localparam logic [15:0] ETH_IPV6 = 16'h86DD;

   typedef struct packed {
      logic        cmd;
      logic [31:0] ip;
      logic [47:0] mac;
      logic [15:0] etype;
   } frame_item_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [47:0] mac;
      logic [2:0]  idx;
   } hop_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_cmd = 1'b0;
   logic [31:0] req_ip_addr = '0;
   logic [47:0] req_peer_mac_in = '0;
   logic [15:0] req_ethertype = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_status;
   logic [47:0] rsp_dest_mac;
   logic [2:0]  rsp_entry_index;
   logic        csr_write = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [47:0] csr_data = '0;

   // predictor copy of registers and table
   logic [31:0]                 cfg_own_ip = '0;
   logic [31:0]                 cfg_mask = '0;
   logic [47:0]                 cfg_gateway_mac = '0;
   logic [31:0]                 peer_ip [ENTRIES];
   logic [47:0]                 peer_mac [ENTRIES];
   logic [arpc_pkg::LIFE_W-1:0] peer_life [ENTRIES];

   frame_item_type pending_frames[$];
   hop_result_type expected_hops[$];
   bit             req_fire = 1'b0;
   int             send_idle_pct = 0;
   int             rsp_stall_pct = 0;
   int             fail_count = 0;
   longint         cycle_count = 0;

   arp_cache_next_hop_top #(
      .TABLE_ENTRIES(ENTRIES)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_cmd(req_cmd),
      .req_ip_addr(req_ip_addr),
      .req_peer_mac_in(req_peer_mac_in),
      .req_ethertype(req_ethertype),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_status(rsp_status),
      .rsp_dest_mac(rsp_dest_mac),
      .rsp_entry_index(rsp_entry_index),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   initial forever #4 clock = ~clock;

   function automatic hop_result_type resolve_hop(frame_item_type f);
      hop_result_type r;
      int slot;
      int i;
      bit in_net;
      r = '0;
      in_net = (f.ip & cfg_mask) == (cfg_own_ip & cfg_mask);
      // only the low 16 ip bits take part in a table hit
      slot = -1;
      for (i = ENTRIES - 1; i >= 0; i--)
         if (peer_life[i] != 0 && peer_ip[i][15:0] == f.ip[15:0]) slot = i;
      if (f.cmd == arpc_pkg::CMD_TX) begin
         if (!in_net) begin
            r.status = arpc_pkg::ST_GATEWAY;
            r.mac = cfg_gateway_mac;
         end else if (slot >= 0) begin
            peer_life[slot] = arpc_pkg::LIFE_FULL;
            r.status = arpc_pkg::ST_DIRECT;
            r.mac = peer_mac[slot];
            r.idx = 3'(slot);
         end else begin
            r.status = arpc_pkg::ST_NEED_ARP;
         end
      end else if (f.etype == arpc_pkg::ETH_IPV4) begin
         if (!in_net) begin
            r.status = arpc_pkg::ST_FOREIGN;
         end else begin
            if (slot < 0) begin
               for (i = ENTRIES - 1; i >= 0; i--)
                  if (peer_life[i] == 0) slot = i;
               if (slot >= 0) begin
                  peer_ip[slot] = f.ip;
                  peer_mac[slot] = f.mac;
               end
            end
            if (slot >= 0) begin
               peer_life[slot] = arpc_pkg::LIFE_FULL;
               r.status = arpc_pkg::ST_LEARNED;
               r.idx = 3'(slot);
            end else begin
               r.status = arpc_pkg::ST_FULL;
            end
         end
      end else if (f.etype == arpc_pkg::ETH_ARP) begin
         r.status = arpc_pkg::ST_ARP_FRAME;
      end else begin
         r.status = arpc_pkg::ST_FOREIGN;
      end
      return r;
   endfunction

   // mostly in-subnet addresses drawn from sixteen keys so the table fills and hits
   function automatic frame_item_type random_frame();
      frame_item_type f;
      int unsigned pick;
      logic [3:0] k;
      f.cmd = 1'($urandom_range(1));
      f.mac = {16'($urandom), $urandom};
      f.etype = 16'($urandom);
      k = 4'($urandom_range(15));
      pick = $urandom_range(9);
      if (pick < 7)
         f.ip = (cfg_own_ip & cfg_mask) | ({16'($urandom), {4{k}}} & ~cfg_mask);
      else
         f.ip = $urandom;
      if (f.cmd == CMD_RX) begin
         pick = $urandom_range(19);
         if (pick < 12) f.etype = arpc_pkg::ETH_IPV4;
         else if (pick < 15) f.etype = arpc_pkg::ETH_ARP;
      end
      return f;
   endfunction

   task automatic queue_frame(logic cmd, logic [31:0] ip, logic [47:0] mac,
                              logic [15:0] etype);
      frame_item_type f;
      f.cmd = cmd;
      f.ip = ip;
      f.mac = mac;
      f.etype = etype;
      pending_frames.push_back(f);
   endtask

   task automatic program_reg(logic [1:0] idx, logic [47:0] data);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      case (idx)
         arpc_pkg::CSR_OWN_IP:      cfg_own_ip = data[31:0];
         arpc_pkg::CSR_SUBNET_MASK: cfg_mask = data[31:0];
         arpc_pkg::CSR_GATEWAY_MAC: cfg_gateway_mac = data;
         default: ;
      endcase
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic run_phase(int idle_pct, int stall_pct);
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      while (pending_frames.size() != 0 || req_valid || expected_hops.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic queue_random(int count);
      int n;
      for (n = 0; n < count; n++) pending_frames.push_back(random_frame());
   endtask

   // request driver: payload holds until its transfer
   always @(negedge clock) begin
      frame_item_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (pending_frames.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            nxt = pending_frames.pop_front();
            req_valid <= 1'b1;
            req_cmd <= nxt.cmd;
            req_ip_addr <= nxt.ip;
            req_peer_mac_in <= nxt.mac;
            req_ethertype <= nxt.etype;
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_stall <= !reset && ($urandom_range(99) < rsp_stall_pct);
   end

   // monitor: check responses before queueing the prediction of a new request
   always @(posedge clock) begin
      hop_result_type want;
      frame_item_type taken;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_hops.size() == 0) begin
            $display("%0t: unexpected response status %0d mac %h index %0d", $time,
                     rsp_status, rsp_dest_mac, rsp_entry_index);
            fail_count++;
         end else begin
            want = expected_hops.pop_front();
            if (rsp_status !== want.status) begin
               $display("%0t: status expected %0d actual %0d", $time, want.status,
                        rsp_status);
               fail_count++;
            end
            if (rsp_dest_mac !== want.mac) begin
               $display("%0t: dest_mac expected %h actual %h", $time, want.mac,
                        rsp_dest_mac);
               fail_count++;
            end
            if (rsp_entry_index !== want.idx) begin
               $display("%0t: entry_index expected %0d actual %0d", $time, want.idx,
                        rsp_entry_index);
               fail_count++;
            end
         end
      end
      req_fire = !reset && req_valid && !req_stall;
      if (req_fire) begin
         taken.cmd = req_cmd;
         taken.ip = req_ip_addr;
         taken.mac = req_peer_mac_in;
         taken.etype = req_ethertype;
         expected_hops.push_back(resolve_hop(taken));
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d responses outstanding", $time, expected_hops.size());
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      foreach (peer_life[i]) begin
         peer_life[i] = '0;
         peer_ip[i] = '0;
         peer_mac[i] = '0;
      end
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // upper csr bits must be dropped for the 32-bit registers
      program_reg(arpc_pkg::CSR_OWN_IP, 48'hDEAD_C0A8_0001);
      program_reg(arpc_pkg::CSR_SUBNET_MASK, 48'hBEEF_FFFF_FF00);
      program_reg(arpc_pkg::CSR_GATEWAY_MAC, 48'h02AA_BBCC_DDEE);

      queue_frame(arpc_pkg::CMD_TX, 32'hC0A8_0005, '0, '0);
      queue_frame(arpc_pkg::CMD_TX, 32'h0A00_0001, '1, '1);
      queue_frame(CMD_RX, 32'hC0A8_0009, 48'h1234_5678_9ABC, arpc_pkg::ETH_ARP);
      queue_frame(CMD_RX, 32'hC0A8_0009, 48'h1234_5678_9ABC, 16'h0000);
      queue_frame(CMD_RX, 32'hC0A8_0009, 48'h1234_5678_9ABC, 16'hFFFF);
      queue_frame(CMD_RX, 32'hC0A8_0009, 48'h1234_5678_9ABC, ETH_IPV6);
      queue_frame(CMD_RX, 32'h0A01_0203, 48'h1234_5678_9ABC, arpc_pkg::ETH_IPV4);
      queue_frame(CMD_RX, 32'hC0A8_0005, 48'h0000_0000_0000, arpc_pkg::ETH_IPV4);
      queue_frame(arpc_pkg::CMD_TX, 32'hC0A8_0005, '1, '0);
      // refresh keeps the stored mac
      queue_frame(CMD_RX, 32'hC0A8_0005, 48'hFFFF_FFFF_FFFF, arpc_pkg::ETH_IPV4);
      queue_frame(arpc_pkg::CMD_TX, 32'hC0A8_0005, '0, '1);
      queue_frame(CMD_RX, 32'hC0A8_00FF, 48'hFFFF_FFFF_FFFF, arpc_pkg::ETH_IPV4);
      queue_frame(arpc_pkg::CMD_TX, 32'hC0A8_00FF, '0, '0);
      queue_frame(arpc_pkg::CMD_TX, 32'hC0A8_0000, '0, '0);
      queue_frame(arpc_pkg::CMD_TX, 32'hFFFF_FFFF, '0, '0);
      queue_frame(arpc_pkg::CMD_TX, 32'h0000_0000, '0, '0);
      run_phase(0, 0);

      // every address in the subnet; matches alias on the low 16 bits
      program_reg(CSR_UNMAPPED, 48'hFFFF_FFFF_FFFF);
      program_reg(arpc_pkg::CSR_OWN_IP, 48'h0);
      program_reg(arpc_pkg::CSR_SUBNET_MASK, 48'h0);
      program_reg(arpc_pkg::CSR_GATEWAY_MAC, 48'hFFFF_FFFF_FFFF);
      queue_frame(arpc_pkg::CMD_TX, 32'h1234_0005, '0, '0);
      queue_frame(CMD_RX, 32'hABCD_00FF, 48'h0101_0101_0101, arpc_pkg::ETH_IPV4);
      queue_frame(arpc_pkg::CMD_TX, 32'h8000_00FF, '0, '0);
      queue_frame(arpc_pkg::CMD_TX, 32'h0000_2000, '0, '0);
      queue_frame(CMD_RX, 32'h5555_2000, 48'h0A0B_0C0D_0E0F, arpc_pkg::ETH_IPV4);
      queue_frame(arpc_pkg::CMD_TX, 32'hFFFF_2000, '0, '0);
      run_phase(0, 0);

      program_reg(arpc_pkg::CSR_OWN_IP, 48'hC0A8_0101);
      program_reg(arpc_pkg::CSR_SUBNET_MASK, 48'hFFFF_FF00);
      program_reg(arpc_pkg::CSR_GATEWAY_MAC, {16'($urandom), $urandom});
      queue_random(RANDOM_PER_PHASE);
      run_phase(0, 0);

      program_reg(arpc_pkg::CSR_OWN_IP, {16'($urandom), $urandom});
      program_reg(arpc_pkg::CSR_SUBNET_MASK, 48'hFFFF_0000);
      program_reg(arpc_pkg::CSR_GATEWAY_MAC, 48'hFFFF_FFFF_FFFF);
      queue_random(RANDOM_PER_PHASE);
      run_phase(57, 0);

      program_reg(arpc_pkg::CSR_OWN_IP, 48'hFFFF_FFFF);
      program_reg(arpc_pkg::CSR_SUBNET_MASK, 48'hFFFF_FFFF);
      program_reg(arpc_pkg::CSR_GATEWAY_MAC, 48'h0);
      queue_random(RANDOM_PER_PHASE);
      run_phase(0, 57);

      program_reg(arpc_pkg::CSR_OWN_IP, 48'h0);
      program_reg(arpc_pkg::CSR_SUBNET_MASK, 48'h0);
      program_reg(arpc_pkg::CSR_GATEWAY_MAC, {16'($urandom), $urandom});
      queue_random(RANDOM_PER_PHASE);
      run_phase(9, 9);

      if (fail_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
`default_nettype wire

### arp_cache_next_hop_top.f
design/arpc_pkg.sv
design/arpc_entry_cell.sv
design/arp_cache_next_hop_top.sv
bench/tb_top.sv
